### hw/rtl/vite_pkg.sv
package vite_pkg;

	localparam int unsigned LINE_W      = 16;
	localparam int unsigned FRAME_W     = 32;
	localparam int unsigned LINE_CMP_W  = LINE_W + 1;
	localparam int unsigned FRAME_CMP_W = FRAME_W + 1;
	localparam int unsigned CFG_INDEX_W = 4;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 56;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LINE_LENGTH     = 4'd0,
		REG_HSYNC_WIDTH     = 4'd1,
		REG_FRAME_LENGTH    = 4'd2,
		REG_VSYNC_LENGTH    = 4'd3,
		REG_ACTIVE_H_WINDOW = 4'd4,
		REG_ACTIVE_V_START  = 4'd5,
		REG_ACTIVE_V_END    = 4'd6,
		REG_SYNC_POLARITY   = 4'd7
	} reg_index_t;

	// packed with the last member at the lowest bit on the output bus
	typedef struct packed {
		logic [FRAME_W-1:0] frame_number;
		logic [LINE_W-1:0]  line_number;
		logic               data_enable;
		logic               vsync_out;
		logic               hsync_out;
	} timing_out_t;

	localparam int unsigned OUT_PAD_W = OUT_TDATA_W - $bits(timing_out_t);

endpackage

### hw/rtl/video_interface_timing_engine_top.sv
// channel   direction  transaction carries
// s_axis    in         one pixel-clock tick: engine_enable
// m_axis    out        hsync_out, vsync_out, data_enable, line_number, frame_number
// cfg       in         register index and write data
//
// One tick each cycle unless stalled; its result is in the output register on the next cycle.
// The counter update and all window compares fit between the counters and the output register.
// arst_n clears counters, output valid and registers to their reset values (totals = 1).
// A stalled output holds; s_axis_tready follows the output register being free or taken.
module video_interface_timing_engine_top import vite_pkg::*; #(
	parameter int unsigned H_COUNT_BITS     = 16,
	parameter int unsigned FRAME_COUNT_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [0] engine_enable
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [0] hsync_out, [1] vsync_out,
	                                              // [2] data_enable, [18:3] line_number,
	                                              // [50:19] frame_number
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [LINE_W-1:0]  line_length_q;
	logic [LINE_W-1:0]  hsync_width_q;
	logic [FRAME_W-1:0] frame_length_q;
	logic [FRAME_W-1:0] vsync_length_q;
	logic [FRAME_W-1:0] active_h_window_q;
	logic [FRAME_W-1:0] active_v_start_q;
	logic [FRAME_W-1:0] active_v_end_q;
	logic [1:0]         sync_polarity_q;

	logic [H_COUNT_BITS-1:0]     pixel_in_line_q;
	logic [FRAME_COUNT_BITS-1:0] pixel_in_frame_q;
	logic [LINE_W-1:0]           line_counter_q;
	logic [FRAME_W-1:0]          frame_counter_q;

	timing_out_t result_q;
	logic        out_valid_q;

	logic                  accept;
	logic                  enable;
	logic [LINE_W-1:0]     pil_ext;
	logic [FRAME_W-1:0]    pif_ext;
	logic [H_COUNT_BITS:0] next_h;
	logic [FRAME_COUNT_BITS:0] next_f;
	logic                  wrap_h;
	logic                  wrap_f;
	logic                  h_in;
	logic                  v_in;
	timing_out_t           result_d;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign enable        = s_axis_tdata[0];

	assign pil_ext = LINE_W'(pixel_in_line_q);
	assign pif_ext = FRAME_W'(pixel_in_frame_q);
	assign next_h  = {1'b0, pixel_in_line_q} + 1'b1;
	assign next_f  = {1'b0, pixel_in_frame_q} + 1'b1;
	assign wrap_h  = (LINE_CMP_W'(next_h) >= {1'b0, line_length_q}) || next_h[H_COUNT_BITS];
	assign wrap_f  = (FRAME_CMP_W'(next_f) >= {1'b0, frame_length_q})
		|| next_f[FRAME_COUNT_BITS];

	assign h_in = (pil_ext >= active_h_window_q[15:0]) && (pil_ext <= active_h_window_q[31:16]);
	assign v_in = (pif_ext >= active_v_start_q) && (pif_ext <= active_v_end_q);

	always_comb begin
		if (enable) begin
			result_d.hsync_out    = (pil_ext < hsync_width_q) ^ sync_polarity_q[0];
			result_d.vsync_out    = (pif_ext < vsync_length_q) ^ sync_polarity_q[1];
			result_d.data_enable  = h_in && v_in;
			result_d.line_number  = line_counter_q;
			result_d.frame_number = frame_counter_q;
		end else begin
			result_d.hsync_out    = sync_polarity_q[0];
			result_d.vsync_out    = sync_polarity_q[1];
			result_d.data_enable  = 1'b0;
			result_d.line_number  = '0;
			result_d.frame_number = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q     <= LINE_W'(1);
			hsync_width_q     <= '0;
			frame_length_q    <= FRAME_W'(1);
			vsync_length_q    <= '0;
			active_h_window_q <= '0;
			active_v_start_q  <= '0;
			active_v_end_q    <= '0;
			sync_polarity_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LINE_LENGTH:     line_length_q     <= cfg_data[LINE_W-1:0];
				REG_HSYNC_WIDTH:     hsync_width_q     <= cfg_data[LINE_W-1:0];
				REG_FRAME_LENGTH:    frame_length_q    <= cfg_data;
				REG_VSYNC_LENGTH:    vsync_length_q    <= cfg_data;
				REG_ACTIVE_H_WINDOW: active_h_window_q <= cfg_data;
				REG_ACTIVE_V_START:  active_v_start_q  <= cfg_data;
				REG_ACTIVE_V_END:    active_v_end_q    <= cfg_data;
				REG_SYNC_POLARITY:   sync_polarity_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_in_line_q  <= '0;
			pixel_in_frame_q <= '0;
			line_counter_q   <= '0;
			frame_counter_q  <= '0;
		end else if (accept) begin
			if (!enable || wrap_f) begin
				pixel_in_line_q  <= '0;
				pixel_in_frame_q <= '0;
				line_counter_q   <= '0;
				frame_counter_q  <= enable ? frame_counter_q + 1'b1 : '0;
			end else begin
				pixel_in_frame_q <= next_f[FRAME_COUNT_BITS-1:0];
				if (wrap_h) begin
					pixel_in_line_q <= '0;
					line_counter_q  <= line_counter_q + 1'b1;
				end else begin
					pixel_in_line_q <= next_h[H_COUNT_BITS-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, result_q};

endmodule

### hw/rtl/vite_checker.sv
module vite_checker import vite_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");

	// one tick in, one result out on the next cycle
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted tick gave no result");

	// an empty output register never blocks input
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// disabled tick reports cleared counters and no display
	a_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tdata[0]
		|=> m_axis_tdata[50:2] == '0)
		else $error("disabled tick not cleared");

	// the tick after a disabled one starts at line and frame zero
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tdata[0]
		##1 s_axis_tvalid && s_axis_tready && s_axis_tdata[0]
		|=> m_axis_tdata[50:3] == '0)
		else $error("counters not restarted after disable");

endmodule

bind video_interface_timing_engine_top vite_checker u_vite_checker (.*);
